### rtl/core/dsrd_pkg.sv
// ----------------------------------------------------------------------------
// dsrd_pkg
// Shared types, codes and constants of the two-axis stepper ramp controller.
// ----------------------------------------------------------------------------
package dsrd_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 32;
  localparam int unsigned CFG_AW          = 4;
  localparam logic [16:0] RATE_UNIT       = 17'd1000;

  localparam logic [15:0] MAX_RATE_RST    = 16'd1000;
  localparam logic [15:0] MAX_ACCEL_RST   = 16'd5000;
  localparam logic [15:0] MAX_TIMEOUT_RST = 16'd30000;

  typedef enum logic [1:0] {
    REG_MAX_RATE    = 2'd0,
    REG_MAX_ACCEL   = 2'd1,
    REG_MAX_TIMEOUT = 2'd2,
    REG_NONE        = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_ABORT = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    RES_NONE    = 2'd0,
    RES_DONE    = 2'd1,
    RES_TIMEOUT = 2'd2,
    RES_OTHER   = 2'd3
  } outcome_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_START,
    OP_ABORT,
    OP_TIMEOUT,
    OP_PREP,
    OP_SQUARE,
    OP_RAMP,
    OP_RATE,
    OP_STEP,
    OP_DONE
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_PREP,
    S_CHK,
    S_SQ,
    S_RAMP,
    S_RATE,
    S_RCHK,
    S_STEP,
    S_FIN,
    S_EMIT,
    S_EMIT1,
    S_EMIT2
  } state_e;

  typedef struct packed {
    cmd_e cmd;
    logic active;
    logic timeout_hit;
    logic start_ok;
    logic accel_ge;
    logic rate_ge;
    logic move_done;
  } dp_status_t;

  typedef struct packed {
    logic valid;
    logic second;
    logic last;
  } emit_t;

  typedef struct packed {
    logic       accepted;
    logic       drive_valid;
    logic [3:0] left_coils;
    logic [3:0] right_coils;
    logic       busy;
    logic [1:0] outcome;
  } res_t;

  function automatic logic [3:0] coil_pattern(input logic [2:0] phase);
    logic [3:0] p;
    case (phase)
      3'd0:    p = 4'h1;
      3'd1:    p = 4'h3;
      3'd2:    p = 4'h2;
      3'd3:    p = 4'h6;
      3'd4:    p = 4'h4;
      3'd5:    p = 4'hC;
      3'd6:    p = 4'h8;
      default: p = 4'h9;
    endcase
    return p;
  endfunction

endpackage

### rtl/core/dual_stepper_ramp_dda.sv
// Start, abort, timeout, idle tick: EXEC, EMIT. Active tick: EXEC, PREP, CHK,
// SQ/RAMP/CHK per ramp step due (~accel/1000), RATE, RCHK, STEP, FIN on a step
// event, then EMIT, or EMIT1, EMIT2 (second result) when the move completes.
// One transaction in flight at a time; the ramp loop sets the tick length. The
// next transaction is taken the cycle after the last result is issued. Reset
// is asynchronous, active low; clears move state, phases, limits to defaults.
// ----------------------------------------------------------------------------
// dual_stepper_ramp_dda
// Two-axis stepper move controller with trapezoidal ramp and DDA stepping.
// ----------------------------------------------------------------------------
module dual_stepper_ramp_dda #(
  parameter int unsigned COUNT_WIDTH = dsrd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dsrd_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 cmd_i,
  input  logic [31:0]                move_tag_i,
  input  logic signed [31:0]         left_count_i,
  input  logic signed [31:0]         right_count_i,
  input  logic [15:0]                peak_rate_i,
  input  logic [15:0]                accel_rate_i,
  input  logic [15:0]                timeout_limit_i,
  input  logic [31:0]                now_time_i,
  input  logic [1:0]                 abort_code_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       accepted_o,
  output logic                       drive_valid_o,
  output logic [3:0]                 left_coils_o,
  output logic [3:0]                 right_coils_o,
  output logic                       busy_res_o,
  output logic [1:0]                 outcome_o,
  output logic                       last_o
);
  import dsrd_pkg::*;

  logic [15:0] max_rate_q, max_accel_q, max_timeout_q;
  reg_idx_e    reg_idx;
  dp_status_t  st;
  op_e         op;
  emit_t       emit;
  res_t        res, res_sel;
  logic        out_valid_q, out_free;
  res_t        out_q;
  logic        last_q;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_comb begin
    case (reg_idx)
      REG_MAX_RATE:    prdata = {16'd0, max_rate_q};
      REG_MAX_ACCEL:   prdata = {16'd0, max_accel_q};
      REG_MAX_TIMEOUT: prdata = {16'd0, max_timeout_q};
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_rate_q    <= MAX_RATE_RST;
      max_accel_q   <= MAX_ACCEL_RST;
      max_timeout_q <= MAX_TIMEOUT_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_MAX_RATE:    max_rate_q    <= pwdata[15:0];
        REG_MAX_ACCEL:   max_accel_q   <= pwdata[15:0];
        REG_MAX_TIMEOUT: max_timeout_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  dsrd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_free_i (out_free),
    .st_i       (st),
    .op_o       (op),
    .emit_o     (emit)
  );

  dsrd_dp #(.COUNT_WIDTH(COUNT_WIDTH)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd_i),
    .left_count_i    (left_count_i),
    .right_count_i   (right_count_i),
    .peak_rate_i     (peak_rate_i),
    .accel_rate_i    (accel_rate_i),
    .timeout_limit_i (timeout_limit_i),
    .now_time_i      (now_time_i),
    .abort_code_i    (abort_code_i),
    .max_rate_i      (max_rate_q),
    .max_accel_i     (max_accel_q),
    .max_timeout_i   (max_timeout_q),
    .op_i            (op),
    .st_o            (st),
    .res_o           (res)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    res_sel = res;
    if (emit.second) begin
      res_sel.accepted    = 1'b0;
      res_sel.drive_valid = 1'b1;
      res_sel.left_coils  = 4'h0;
      res_sel.right_coils = 4'h0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= emit.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && emit.valid) begin
      out_q  <= res_sel;
      last_q <= emit.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign accepted_o    = out_q.accepted;
  assign drive_valid_o = out_q.drive_valid;
  assign left_coils_o  = out_q.left_coils;
  assign right_coils_o = out_q.right_coils;
  assign busy_res_o    = out_q.busy;
  assign outcome_o     = out_q.outcome;
  assign last_o        = last_q;

endmodule

### rtl/core/dsrd_ctrl.sv
// ----------------------------------------------------------------------------
// dsrd_ctrl
// Sequencer: decodes the transaction, runs the ramp loop and issues results.
// ----------------------------------------------------------------------------
module dsrd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                out_free_i,
  input  dsrd_pkg::dp_status_t st_i,
  output dsrd_pkg::op_e       op_o,
  output dsrd_pkg::emit_t     emit_o
);
  import dsrd_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    op_o       = OP_NONE;
    emit_o     = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          op_o    = OP_LATCH;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_EMIT;
        case (st_i.cmd)
          CMD_START: if (st_i.start_ok) op_o = OP_START;
          CMD_TICK: begin
            if (st_i.active) begin
              if (st_i.timeout_hit) begin
                op_o = OP_TIMEOUT;
              end else begin
                state_d = S_PREP;
              end
            end
          end
          CMD_ABORT: op_o = OP_ABORT;
          default:   op_o = OP_NONE;
        endcase
      end
      S_PREP: begin
        op_o    = OP_PREP;
        state_d = S_CHK;
      end
      S_CHK: begin
        state_d = st_i.accel_ge ? S_SQ : S_RATE;
      end
      S_SQ: begin
        op_o    = OP_SQUARE;
        state_d = S_RAMP;
      end
      S_RAMP: begin
        op_o    = OP_RAMP;
        state_d = S_CHK;
      end
      S_RATE: begin
        op_o    = OP_RATE;
        state_d = S_RCHK;
      end
      S_RCHK: begin
        state_d = st_i.rate_ge ? S_STEP : S_EMIT;
      end
      S_STEP: begin
        op_o    = OP_STEP;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (st_i.move_done) begin
          op_o    = OP_DONE;
          state_d = S_EMIT1;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free_i) begin
          emit_o  = '{valid: 1'b1, second: 1'b0, last: 1'b1};
          state_d = S_IDLE;
        end
      end
      S_EMIT1: begin
        if (out_free_i) begin
          emit_o  = '{valid: 1'b1, second: 1'b0, last: 1'b0};
          state_d = S_EMIT2;
        end
      end
      S_EMIT2: begin
        if (out_free_i) begin
          emit_o  = '{valid: 1'b1, second: 1'b1, last: 1'b1};
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

### rtl/core/dsrd_dp.sv
// ----------------------------------------------------------------------------
// dsrd_dp
// Move state, ramp arithmetic, rate accumulator and two-axis DDA.
// ----------------------------------------------------------------------------
module dsrd_dp #(
  parameter int unsigned COUNT_WIDTH = dsrd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [1:0]           cmd_i,
  input  logic [31:0]          left_count_i,
  input  logic [31:0]          right_count_i,
  input  logic [15:0]          peak_rate_i,
  input  logic [15:0]          accel_rate_i,
  input  logic [15:0]          timeout_limit_i,
  input  logic [31:0]          now_time_i,
  input  logic [1:0]           abort_code_i,
  input  logic [15:0]          max_rate_i,
  input  logic [15:0]          max_accel_i,
  input  logic [15:0]          max_timeout_i,
  input  dsrd_pkg::op_e        op_i,
  output dsrd_pkg::dp_status_t st_o,
  output dsrd_pkg::res_t       res_o
);
  import dsrd_pkg::*;

  localparam int unsigned CW = COUNT_WIDTH;
  localparam int unsigned PW = CW + 17;

  cmd_e        cmd_q;
  logic [31:0] lg_q, rg_q, now_q;
  logic [15:0] pk_in_q, ac_in_q, to_in_q;
  logic [1:0]  abort_q;

  logic          active_q;
  logic          lsign_q, rsign_q;
  logic [CW-1:0] la_q, ra_q, major_q;
  logic [CW-1:0] ltaken_q, rtaken_q, lerr_q, rerr_q;
  logic [31:0]   rate_acc_q, start_time_q;
  logic [16:0]   accel_acc_q;
  logic [15:0]   cur_rate_q, peak_q, accel_q, timeout_q;
  logic [1:0]    outcome_q;
  logic [2:0]    lphase_q, rphase_q;
  logic [PW-1:0] prod_q;
  logic          rem_zero_q;
  logic [31:0]   sq_q;
  logic          res_acc_q, res_dv_q;
  logic [3:0]    lc_q, rc_q;

  logic [31:0]   lmag, rmag, elapsed;
  logic [CW-1:0] most, rem, rem_m1;
  logic          brake;
  logic [CW:0]   le, re, le_n, re_n;
  logic          lstep, rstep;
  logic [2:0]    lph_n, rph_n;

  always_comb begin
    lmag    = lg_q[31] ? (32'd0 - lg_q) : lg_q;
    rmag    = rg_q[31] ? (32'd0 - rg_q) : rg_q;
    elapsed = now_q - start_time_q;
    most    = (ltaken_q > rtaken_q) ? ltaken_q : rtaken_q;
    rem     = major_q - most;
    rem_m1  = rem - CW'(1);
    brake   = rem_zero_q || (prod_q <= PW'(sq_q));
    le      = {1'b0, lerr_q} + {1'b0, la_q};
    re      = {1'b0, rerr_q} + {1'b0, ra_q};
    lstep   = (ltaken_q < la_q) && (le >= {1'b0, major_q});
    rstep   = (rtaken_q < ra_q) && (re >= {1'b0, major_q});
    le_n    = lstep ? (le - {1'b0, major_q}) : le;
    re_n    = rstep ? (re - {1'b0, major_q}) : re;
    lph_n   = lstep ? (lsign_q ? lphase_q - 3'd1 : lphase_q + 3'd1) : lphase_q;
    rph_n   = rstep ? (rsign_q ? rphase_q - 3'd1 : rphase_q + 3'd1) : rphase_q;

    st_o.cmd         = cmd_q;
    st_o.active      = active_q;
    st_o.timeout_hit = elapsed >= {16'd0, timeout_q};
    st_o.start_ok    = !active_q && !(lg_q == 32'd0 && rg_q == 32'd0) &&
                       pk_in_q != 16'd0 && pk_in_q <= max_rate_i &&
                       ac_in_q != 16'd0 && ac_in_q <= max_accel_i &&
                       to_in_q != 16'd0 && to_in_q <= max_timeout_i &&
                       (lmag >> CW) == 32'd0 && (rmag >> CW) == 32'd0;
    st_o.accel_ge    = accel_acc_q >= RATE_UNIT;
    st_o.rate_ge     = rate_acc_q >= {15'd0, RATE_UNIT};
    st_o.move_done   = (ltaken_q >= la_q) && (rtaken_q >= ra_q);

    res_o.accepted    = res_acc_q;
    res_o.drive_valid = res_dv_q;
    res_o.left_coils  = lc_q;
    res_o.right_coils = rc_q;
    res_o.busy        = active_q;
    res_o.outcome     = outcome_q;
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LATCH: begin
        cmd_q   <= cmd_e'(cmd_i);
        lg_q    <= left_count_i;
        rg_q    <= right_count_i;
        pk_in_q <= peak_rate_i;
        ac_in_q <= accel_rate_i;
        to_in_q <= timeout_limit_i;
        now_q   <= now_time_i;
        abort_q <= abort_code_i;
      end
      OP_PREP: begin
        prod_q     <= PW'(rem_m1) * PW'({accel_q, 1'b0});
        rem_zero_q <= rem == '0;
      end
      OP_SQUARE: sq_q <= 32'(cur_rate_q) * 32'(cur_rate_q);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      lsign_q      <= 1'b0;
      rsign_q      <= 1'b0;
      la_q         <= '0;
      ra_q         <= '0;
      major_q      <= '0;
      ltaken_q     <= '0;
      rtaken_q     <= '0;
      lerr_q       <= '0;
      rerr_q       <= '0;
      rate_acc_q   <= '0;
      accel_acc_q  <= '0;
      cur_rate_q   <= '0;
      peak_q       <= '0;
      accel_q      <= '0;
      timeout_q    <= '0;
      start_time_q <= '0;
      outcome_q    <= RES_NONE;
      lphase_q     <= '0;
      rphase_q     <= '0;
      res_acc_q    <= 1'b0;
      res_dv_q     <= 1'b0;
      lc_q         <= '0;
      rc_q         <= '0;
    end else begin
      case (op_i)
        OP_LATCH: begin
          res_acc_q <= 1'b0;
          res_dv_q  <= 1'b0;
          lc_q      <= '0;
          rc_q      <= '0;
        end
        OP_START: begin
          active_q     <= 1'b1;
          lsign_q      <= lg_q[31];
          rsign_q      <= rg_q[31];
          la_q         <= lmag[CW-1:0];
          ra_q         <= rmag[CW-1:0];
          major_q      <= (lmag > rmag) ? lmag[CW-1:0] : rmag[CW-1:0];
          ltaken_q     <= '0;
          rtaken_q     <= '0;
          lerr_q       <= '0;
          rerr_q       <= '0;
          rate_acc_q   <= '0;
          accel_acc_q  <= '0;
          cur_rate_q   <= 16'd1;
          peak_q       <= pk_in_q;
          accel_q      <= ac_in_q;
          timeout_q    <= to_in_q;
          start_time_q <= now_q;
          outcome_q    <= RES_NONE;
          res_acc_q    <= 1'b1;
        end
        OP_ABORT: begin
          active_q  <= 1'b0;
          outcome_q <= abort_q;
          res_dv_q  <= 1'b1;
        end
        OP_TIMEOUT: begin
          active_q  <= 1'b0;
          outcome_q <= RES_TIMEOUT;
          res_dv_q  <= 1'b1;
        end
        OP_PREP: accel_acc_q <= accel_acc_q + {1'b0, accel_q};
        OP_RAMP: begin
          accel_acc_q <= accel_acc_q - RATE_UNIT;
          if (brake) begin
            if (cur_rate_q > 16'd1) cur_rate_q <= cur_rate_q - 16'd1;
          end else if (cur_rate_q < peak_q) begin
            cur_rate_q <= cur_rate_q + 16'd1;
          end
        end
        OP_RATE: rate_acc_q <= rate_acc_q + {16'd0, cur_rate_q};
        OP_STEP: begin
          rate_acc_q <= rate_acc_q - {15'd0, RATE_UNIT};
          if (lstep) ltaken_q <= ltaken_q + CW'(1);
          if (rstep) rtaken_q <= rtaken_q + CW'(1);
          lerr_q   <= le_n[CW-1:0];
          rerr_q   <= re_n[CW-1:0];
          lphase_q <= lph_n;
          rphase_q <= rph_n;
          res_dv_q <= 1'b1;
          lc_q     <= (la_q == '0) ? 4'h0 : coil_pattern(lph_n);
          rc_q     <= (ra_q == '0) ? 4'h0 : coil_pattern(rph_n);
        end
        OP_DONE: begin
          active_q  <= 1'b0;
          outcome_q <= RES_DONE;
        end
        default: ;
      endcase
    end
  end

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-axis stepper ramp controller: a directed
// and a random sequence of move, tick and abort transactions are driven, the
// random one over several limit settings written through the register port
// and with random idling on both sides in all but one, and every result is
// checked against a local model of the ramp, the timeout and the DDA stepping.
// ----------------------------------------------------------------------------
module tb;
  import dsrd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] tag;
    logic [31:0] lcnt;
    logic [31:0] rcnt;
    logic [15:0] peak;
    logic [15:0] accel;
    logic [15:0] tmo;
    logic [31:0] now;
    logic [1:0]  acode;
  } move_cmd_t;

  typedef struct packed {
    logic       accepted;
    logic       drive_valid;
    logic [3:0] lcoils;
    logic [3:0] rcoils;
    logic       busy;
    logic [1:0] outcome;
    logic       last;
  } coil_res_t;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic [1:0] cmd_i, abort_code_i;
  logic [31:0] move_tag_i, now_time_i;
  logic signed [31:0] left_count_i, right_count_i;
  logic [15:0] peak_rate_i, accel_rate_i, timeout_limit_i;
  logic accepted_o, drive_valid_o, busy_res_o, last_o;
  logic [3:0] left_coils_o, right_coils_o;
  logic [1:0] outcome_o;

  dual_stepper_ramp_dda dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  move_cmd_t pending_q[$];
  coil_res_t expected_q[$];
  int errors = 0;
  int checked = 0;
  int moves_done = 0;
  int timeouts = 0;
  longint cycles = 0;
  bit quiet = 0;
  bit in_fire = 0;

  // model state
  logic [15:0] lim_rate, lim_accel, lim_tmo;
  bit          m_active;
  logic [31:0] m_lgoal, m_rgoal, m_ltaken, m_rtaken, m_major, m_lerr, m_rerr;
  logic [31:0] m_rate_acc, m_start;
  logic [16:0] m_accel_acc;
  logic [15:0] m_rate, m_peak, m_accel, m_tmo;
  logic [1:0]  m_outcome;
  logic [2:0]  m_lph, m_rph;

  function automatic logic [31:0] mag(logic [31:0] v);
    return v[31] ? -v : v;
  endfunction

  function automatic logic [3:0] coil_of(logic [2:0] ph);
    logic [3:0] t[8] = '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};
    return t[ph];
  endfunction

  task automatic push_res(bit acc, bit dv, logic [3:0] lc, logic [3:0] rc, bit lst);
    coil_res_t r;
    r.accepted = acc; r.drive_valid = dv; r.lcoils = lc; r.rcoils = rc;
    r.busy = m_active; r.outcome = m_outcome; r.last = lst;
    expected_q.push_back(r);
  endtask

  task automatic predict_coils(move_cmd_t c);
    logic [31:0] la, ra, most;
    logic [32:0] e;
    logic [63:0] remaining, brake;
    logic [3:0] lc, rc;
    case (c.cmd)
      CMD_START: begin
        la = mag(c.lcnt); ra = mag(c.rcnt);
        if (m_active || (c.lcnt == 0 && c.rcnt == 0) || c.peak == 0 ||
            c.peak > lim_rate || c.accel == 0 || c.accel > lim_accel ||
            c.tmo == 0 || c.tmo > lim_tmo) begin
          push_res(0, 0, 0, 0, 1);
        end else begin
          m_active = 1; m_lgoal = c.lcnt; m_rgoal = c.rcnt;
          m_ltaken = 0; m_rtaken = 0; m_major = (la > ra) ? la : ra;
          m_lerr = 0; m_rerr = 0; m_rate_acc = 0; m_accel_acc = 0; m_rate = 1;
          m_peak = c.peak; m_accel = c.accel; m_tmo = c.tmo; m_start = c.now;
          m_outcome = RES_NONE;
          push_res(1, 0, 0, 0, 1);
        end
      end
      CMD_TICK: begin
        if (!m_active) begin
          push_res(0, 0, 0, 0, 1);
        end else if (c.now - m_start >= {16'd0, m_tmo}) begin
          m_active = 0; m_outcome = RES_TIMEOUT; timeouts++;
          push_res(0, 1, 0, 0, 1);
        end else begin
          most = (m_ltaken > m_rtaken) ? m_ltaken : m_rtaken;
          remaining = {32'd0, m_major - most};
          m_accel_acc = m_accel_acc + {1'b0, m_accel};
          while (m_accel_acc >= 17'd1000) begin
            m_accel_acc -= 17'd1000;
            brake = (64'(m_rate) * 64'(m_rate)) / (64'(m_accel) * 2) + 1;
            if (remaining <= brake) begin
              if (m_rate > 1) m_rate--;
            end else if (m_rate < m_peak) m_rate++;
          end
          m_rate_acc = m_rate_acc + {16'd0, m_rate};
          if (m_rate_acc < 32'd1000) begin
            push_res(0, 0, 0, 0, 1);
          end else begin
            m_rate_acc -= 32'd1000;
            la = mag(m_lgoal); ra = mag(m_rgoal);
            e = {1'b0, m_lerr} + {1'b0, la};
            if (m_ltaken < la && e >= {1'b0, m_major}) begin
              e -= {1'b0, m_major}; m_ltaken++;
              m_lph = m_lgoal[31] ? m_lph - 1 : m_lph + 1;
            end
            m_lerr = e[31:0];
            e = {1'b0, m_rerr} + {1'b0, ra};
            if (m_rtaken < ra && e >= {1'b0, m_major}) begin
              e -= {1'b0, m_major}; m_rtaken++;
              m_rph = m_rgoal[31] ? m_rph - 1 : m_rph + 1;
            end
            m_rerr = e[31:0];
            lc = (la == 0) ? 4'h0 : coil_of(m_lph);
            rc = (ra == 0) ? 4'h0 : coil_of(m_rph);
            if (m_ltaken >= la && m_rtaken >= ra) begin
              m_active = 0; m_outcome = RES_DONE; moves_done++;
              push_res(0, 1, lc, rc, 0);
              push_res(0, 1, 0, 0, 1);
            end else push_res(0, 1, lc, rc, 1);
          end
        end
      end
      CMD_ABORT: begin
        m_active = 0; m_outcome = c.acode;
        push_res(0, 1, 0, 0, 1);
      end
      default: push_res(0, 0, 0, 0, 1);
    endcase
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch at result %0d: %s got %0h expected %0h", checked, what, got, want);
  endtask

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_fire) begin
        if (pending_q.size() > 0 && (quiet || $urandom_range(99) >= 21)) begin
          move_cmd_t c;
          c = pending_q.pop_front();
          predict_coils(c);
          in_valid_i <= 1'b1;
          cmd_i <= c.cmd; move_tag_i <= c.tag; left_count_i <= c.lcnt;
          right_count_i <= c.rcnt; peak_rate_i <= c.peak; accel_rate_i <= c.accel;
          timeout_limit_i <= c.tmo; now_time_i <= c.now; abort_code_i <= c.acode;
        end else in_valid_i <= 1'b0;
      end
      out_stall_i <= quiet ? 1'b0 : ($urandom_range(99) < 21);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    cycles++;
    in_fire <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      coil_res_t w;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        w = expected_q.pop_front();
        if (accepted_o !== w.accepted) report_mismatch("accepted", accepted_o, w.accepted);
        if (drive_valid_o !== w.drive_valid)
          report_mismatch("drive_valid", drive_valid_o, w.drive_valid);
        if (left_coils_o !== w.lcoils) report_mismatch("left_coils", left_coils_o, w.lcoils);
        if (right_coils_o !== w.rcoils)
          report_mismatch("right_coils", right_coils_o, w.rcoils);
        if (busy_res_o !== w.busy) report_mismatch("busy", busy_res_o, w.busy);
        if (outcome_o !== w.outcome) report_mismatch("outcome", outcome_o, w.outcome);
        if (last_o !== w.last) report_mismatch("last", last_o, w.last);
      end
      checked++;
    end
    if (cycles > 3000000) begin
      $display("timeout after %0d cycles", cycles);
      $display("dual_stepper_ramp_dda test failed");
      $finish;
    end
  end

  task automatic write_limit(reg_idx_e idx, logic [15:0] v);
    @(negedge clk_i);
    psel <= 1; pwrite <= 1; paddr <= CFG_AW'(idx) << 2; pwdata <= {16'd0, v};
    @(negedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_MAX_RATE:  lim_rate = v;
      REG_MAX_ACCEL: lim_accel = v;
      default:       lim_tmo = v;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_q.size() > 0 || expected_q.size() > 0 || in_valid_i) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  function automatic move_cmd_t mk(cmd_e cmd, logic [31:0] l, logic [31:0] r,
      logic [15:0] pk, logic [15:0] ac, logic [15:0] to, logic [31:0] now);
    move_cmd_t c;
    c.cmd = cmd; c.tag = $urandom; c.lcnt = l; c.rcnt = r; c.peak = pk;
    c.accel = ac; c.tmo = to; c.now = now; c.acode = $urandom_range(3);
    return c;
  endfunction

  // one well-formed move: start, a run of ticks, sometimes an abort
  task automatic queue_move(ref logic [31:0] clk_ms);
    logic [31:0] l, r;
    int n;
    l = $urandom_range(1) ? $urandom_range(40) : $urandom_range(3);
    r = $urandom_range(40);
    if ($urandom_range(1)) l = -l;
    if ($urandom_range(1)) r = -r;
    pending_q.push_back(mk(CMD_START, l, r,
      ($urandom_range(9) == 0) ? lim_rate : $urandom_range(1, lim_rate),
      ($urandom_range(9) == 0) ? lim_accel : $urandom_range(1, (lim_accel < 3000) ? lim_accel : 3000),
      ($urandom_range(4) == 0) ? $urandom_range(1, 60) : lim_tmo, clk_ms));
    n = $urandom_range(5, 50);
    repeat (n) begin
      clk_ms += $urandom_range(5) == 0 ? $urandom_range(0, 20) : 1;
      pending_q.push_back(mk(CMD_TICK, $urandom, $urandom, $urandom, $urandom,
        $urandom, clk_ms));
    end
    if ($urandom_range(5) == 0) pending_q.push_back(mk(CMD_ABORT, 0, 0, 0, 0, 0, clk_ms));
  endtask

  initial begin
    logic [31:0] ms;
    int total;
    int phase;
    rst_ni = 0; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid_i = 0; out_stall_i = 0; cmd_i = CMD_NOP; move_tag_i = 0;
    left_count_i = 0; right_count_i = 0; peak_rate_i = 0; accel_rate_i = 0;
    timeout_limit_i = 0; now_time_i = 0; abort_code_i = 0;
    lim_rate = MAX_RATE_RST; lim_accel = MAX_ACCEL_RST; lim_tmo = MAX_TIMEOUT_RST;
    m_active = 0; m_lgoal = 0; m_rgoal = 0; m_ltaken = 0; m_rtaken = 0; m_major = 0;
    m_lerr = 0; m_rerr = 0; m_rate_acc = 0; m_start = 0; m_accel_acc = 0;
    m_rate = 0; m_peak = 0; m_accel = 0; m_tmo = 0; m_outcome = RES_NONE;
    m_lph = 0; m_rph = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed: rejections, extremes, abort when idle, command 3
    ms = 32'hFFFF_FFF0;
    pending_q.push_back(mk(CMD_TICK, 0, 0, 0, 0, 0, ms));
    pending_q.push_back(mk(CMD_ABORT, 0, 0, 0, 0, 0, ms));
    pending_q.push_back(mk(CMD_NOP, '1, '1, '1, '1, '1, '1));
    pending_q.push_back(mk(CMD_START, 0, 0, 500, 500, 100, ms));
    pending_q.push_back(mk(CMD_START, 5, 0, 0, 500, 100, ms));
    pending_q.push_back(mk(CMD_START, 5, 0, 1001, 500, 100, ms));
    pending_q.push_back(mk(CMD_START, 5, 0, 500, 0, 100, ms));
    pending_q.push_back(mk(CMD_START, 5, 0, 500, 5001, 100, ms));
    pending_q.push_back(mk(CMD_START, 5, 0, 500, 500, 0, ms));
    pending_q.push_back(mk(CMD_START, 5, 0, 500, 500, 30001, ms));
    pending_q.push_back(mk(CMD_START, 32'h8000_0000, 32'h7FFF_FFFF, 1000, 5000, 30000, ms));
    pending_q.push_back(mk(CMD_START, 3, 3, 1000, 5000, 30000, ms));
    pending_q.push_back(mk(CMD_TICK, 0, 0, 0, 0, 0, ms + 5));
    pending_q.push_back(mk(CMD_TICK, 0, 0, 0, 0, 0, ms + 29999));
    pending_q.push_back(mk(CMD_TICK, 0, 0, 0, 0, 0, ms + 30000));
    pending_q.push_back(mk(CMD_START, -2, 1, 1000, 5000, 30000, 0));
    for (int i = 1; i <= 6; i++) pending_q.push_back(mk(CMD_TICK, 0, 0, 0, 0, 0, i));
    pending_q.push_back(mk(CMD_START, 0, -3, 1, 1, 65535, 0));
    pending_q.push_back(mk(CMD_ABORT, 0, 0, 0, 0, 0, 0));
    quiet = 1;
    wait_idle();
    quiet = 0;

    total = 0;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin write_limit(REG_MAX_RATE, 16'hFFFF); write_limit(REG_MAX_ACCEL, 16'hFFFF);
                 write_limit(REG_MAX_TIMEOUT, 16'hFFFF); end
        1: begin write_limit(REG_MAX_RATE, 1); write_limit(REG_MAX_ACCEL, 1);
                 write_limit(REG_MAX_TIMEOUT, 1); end
        2: begin write_limit(REG_MAX_RATE, 2000); write_limit(REG_MAX_ACCEL, 3000);
                 write_limit(REG_MAX_TIMEOUT, 200); end
        default: begin write_limit(REG_MAX_RATE, 1000); write_limit(REG_MAX_ACCEL, 5000);
                 write_limit(REG_MAX_TIMEOUT, 30000); end
      endcase
      quiet = (phase == 2);
      while (total < 390 * (phase + 1)) begin
        int queued;
        queued = pending_q.size();
        if ($urandom_range(9) == 0) begin
          move_cmd_t c;
          c = mk(cmd_e'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom);
          pending_q.push_back(c);
        end else queue_move(ms);
        total += pending_q.size() - queued;
        while (pending_q.size() > 20) @(posedge clk_i);
      end
      wait_idle();
    end

    $display("checked %0d results over %0d transactions; %0d moves completed, %0d timed out",
      checked, total, moves_done, timeouts);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("dual_stepper_ramp_dda test passed");
    end else begin
      $display("dual_stepper_ramp_dda test failed");
    end
    $finish;
  end
endmodule
